/* hw/rtl/met_pkg.sv */
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants of the escape-time color block
// Field widths, palette constants, multiplier op codes and the command and
// status words exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int COORD_W  = 32;
    localparam int ITER_W   = 16;
    localparam int COLOR_W  = 8;
    localparam int T_FRAC   = 16;
    localparam int MUL_W    = T_FRAC + 1;

    localparam int LIMIT_RESET = 200;

    localparam logic [MUL_W-1:0] ONE_Q = MUL_W'(1) << T_FRAC;
    localparam logic [MUL_W-1:0] RED_K = MUL_W'(2295);
    localparam logic [MUL_W-1:0] GRN_K = MUL_W'(3825);
    localparam logic [MUL_W-1:0] BLU_K = MUL_W'(4335);
    localparam logic [COLOR_W-1:0] COLOR_MAX = '1;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_T2,
        MUL_T3,
        MUL_U2,
        MUL_U3,
        MUL_PR,
        MUL_PG,
        MUL_PB,
        MUL_RED,
        MUL_GRN,
        MUL_BLU
    } met_mul_op_t;

    typedef struct packed {
        logic        load;
        logic        iter;
        logic        div_init;
        logic        div_step;
        met_mul_op_t mul_op;
        logic        out_load;
    } met_cmd_t;

    typedef struct packed {
        logic escape;
        logic at_limit;
    } met_status_t;

    function automatic met_mul_op_t met_next_op(input met_mul_op_t op);
        met_mul_op_t nxt;
        unique case (op)
            MUL_NONE: nxt = MUL_T2;
            MUL_T2:   nxt = MUL_T3;
            MUL_T3:   nxt = MUL_U2;
            MUL_U2:   nxt = MUL_U3;
            MUL_U3:   nxt = MUL_PR;
            MUL_PR:   nxt = MUL_PG;
            MUL_PG:   nxt = MUL_PB;
            MUL_PB:   nxt = MUL_RED;
            MUL_RED:  nxt = MUL_GRN;
            MUL_GRN:  nxt = MUL_BLU;
            MUL_BLU:  nxt = MUL_NONE;
            default:  nxt = MUL_NONE;
        endcase
        return nxt;
    endfunction

endpackage

/* hw/rtl/met_if.sv */
// ----------------------------------------------------------------------------
// met_if: valid/ready channels of the escape-time color block
// One channel carries a point word, the other a result word.
// ----------------------------------------------------------------------------
interface met_point_if import met_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] c_re;
    logic signed [COORD_W-1:0] c_im;

    modport source (output valid, output c_re, output c_im, input ready);
    modport sink (input valid, input c_re, input c_im, output ready);
endinterface

interface met_result_if import met_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ITER_W-1:0]  iterations;
    logic               in_set;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, output iterations, output in_set, output red,
                    output green, output blue, input ready);
    modport sink (input valid, input iterations, input in_set, input red,
                  input green, input blue, output ready);
endinterface

/* hw/rtl/met_datapath.sv */
// ----------------------------------------------------------------------------
// met_datapath: iteration, division and palette datapath
// Complex iteration unit, radix-2 divider for t and a shared 17x17
// multiplier that steps through the palette polynomial.
// ----------------------------------------------------------------------------
module met_datapath import met_pkg::*; #(
    parameter int COORD_FRAC_BITS = 27,
    parameter int ITER_BITS = 16,
    localparam int IW = (ITER_BITS < ITER_W) ? ITER_BITS : ITER_W
) (
    input  logic                      clk,
    input  met_cmd_t                  cmd,
    output met_status_t               status,
    input  logic [IW-1:0]             iter_limit,
    input  logic signed [COORD_W-1:0] c_re,
    input  logic signed [COORD_W-1:0] c_im,
    output logic [ITER_W-1:0]         iterations,
    output logic                      in_set,
    output logic [COLOR_W-1:0]        red,
    output logic [COLOR_W-1:0]        green,
    output logic [COLOR_W-1:0]        blue
);

    localparam int ZW = (COORD_FRAC_BITS + 7 > 34) ? COORD_FRAC_BITS + 7 : 34;
    localparam int PW = 2 * ZW;
    localparam int QW = PW - COORD_FRAC_BITS;
    localparam logic signed [QW:0] FOUR = (QW + 1)'(4) << COORD_FRAC_BITS;

    logic signed [ZW-1:0] x_reg;
    logic signed [ZW-1:0] y_reg;
    logic signed [ZW-1:0] cr_reg;
    logic signed [ZW-1:0] ci_reg;
    logic [IW-1:0]        count_reg;

    logic signed [PW-1:0] xx_p;
    logic signed [PW-1:0] yy_p;
    logic signed [PW-1:0] xy_p;
    logic signed [QW-1:0] xx;
    logic signed [QW-1:0] yy;
    logic signed [QW-1:0] xy;
    logic signed [QW:0]   mag;
    logic signed [ZW-1:0] x_next;
    logic signed [ZW-1:0] y_next;

    logic [IW-1:0]       rem_reg;
    logic [IW:0]         rem_shift;
    logic [IW:0]         max_ext;
    logic [T_FRAC-1:0]   t_reg;

    logic [MUL_W-1:0]    u;
    logic [MUL_W-1:0]    t2_reg;
    logic [MUL_W-1:0]    t3_reg;
    logic [MUL_W-1:0]    u2_reg;
    logic [MUL_W-1:0]    u3_reg;
    logic [MUL_W-1:0]    pr_reg;
    logic [MUL_W-1:0]    pg_reg;
    logic [MUL_W-1:0]    pb_reg;
    logic [COLOR_W-1:0]  red_c_reg;
    logic [COLOR_W-1:0]  grn_c_reg;
    logic [COLOR_W-1:0]  blu_c_reg;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  mul_p;
    logic [MUL_W-1:0]    mul_q;
    logic [2*MUL_W-1:0]  p_sh16;
    logic [2*MUL_W-1:0]  p_sh17;
    logic [COLOR_W-1:0]  sat16;
    logic [COLOR_W-1:0]  sat17;

    logic [ITER_W-1:0]   iter_reg;
    logic                in_set_reg;
    logic [COLOR_W-1:0]  red_reg;
    logic [COLOR_W-1:0]  green_reg;
    logic [COLOR_W-1:0]  blue_reg;

    assign xx_p = PW'(x_reg) * PW'(x_reg);
    assign yy_p = PW'(y_reg) * PW'(y_reg);
    assign xy_p = PW'(x_reg) * PW'(y_reg);
    assign xx   = QW'(xx_p >>> COORD_FRAC_BITS);
    assign yy   = QW'(yy_p >>> COORD_FRAC_BITS);
    assign xy   = QW'(xy_p >>> COORD_FRAC_BITS);
    assign mag  = (QW + 1)'(xx) + (QW + 1)'(yy);

    assign x_next = ZW'(xx - yy + QW'(cr_reg));
    assign y_next = ZW'((xy <<< 1) + QW'(ci_reg));

    assign status.escape   = (mag > FOUR) || (count_reg >= iter_limit);
    assign status.at_limit = (count_reg == iter_limit);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg    <= ZW'(c_re);
            ci_reg    <= ZW'(c_im);
            x_reg     <= '0;
            y_reg     <= '0;
            count_reg <= '0;
        end
        else if (cmd.iter)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            count_reg <= count_reg + IW'(1);
        end
    end

    assign rem_shift = {rem_reg, 1'b0};
    assign max_ext   = {1'b0, iter_limit};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= count_reg;
            t_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_shift >= max_ext)
            begin
                rem_reg <= IW'(rem_shift - max_ext);
                t_reg   <= {t_reg[T_FRAC-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= IW'(rem_shift);
                t_reg   <= {t_reg[T_FRAC-2:0], 1'b0};
            end
        end
    end

    assign u = ONE_Q - MUL_W'(t_reg);

    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_NONE: begin mul_a = '0;            mul_b = '0;            end
            MUL_T2:   begin mul_a = MUL_W'(t_reg); mul_b = MUL_W'(t_reg); end
            MUL_T3:   begin mul_a = t2_reg;        mul_b = MUL_W'(t_reg); end
            MUL_U2:   begin mul_a = u;             mul_b = u;             end
            MUL_U3:   begin mul_a = u2_reg;        mul_b = u;             end
            MUL_PR:   begin mul_a = u;             mul_b = t3_reg;        end
            MUL_PG:   begin mul_a = u2_reg;        mul_b = t2_reg;        end
            MUL_PB:   begin mul_a = u3_reg;        mul_b = MUL_W'(t_reg); end
            MUL_RED:  begin mul_a = RED_K;         mul_b = pr_reg;        end
            MUL_GRN:  begin mul_a = GRN_K;         mul_b = pg_reg;        end
            MUL_BLU:  begin mul_a = BLU_K;         mul_b = pb_reg;        end
            default:  begin mul_a = '0;            mul_b = '0;            end
        endcase
    end

    assign mul_p  = (2 * MUL_W)'(mul_a) * (2 * MUL_W)'(mul_b);
    assign mul_q  = MUL_W'(mul_p >> T_FRAC);
    assign p_sh16 = mul_p >> 16;
    assign p_sh17 = mul_p >> 17;
    assign sat16  = (p_sh16 > (2 * MUL_W)'(COLOR_MAX)) ? COLOR_MAX : COLOR_W'(p_sh16);
    assign sat17  = (p_sh17 > (2 * MUL_W)'(COLOR_MAX)) ? COLOR_MAX : COLOR_W'(p_sh17);

    always_ff @(posedge clk)
    begin
        unique case (cmd.mul_op)
            MUL_NONE: ;
            MUL_T2:   t2_reg    <= mul_q;
            MUL_T3:   t3_reg    <= mul_q;
            MUL_U2:   u2_reg    <= mul_q;
            MUL_U3:   u3_reg    <= mul_q;
            MUL_PR:   pr_reg    <= mul_q;
            MUL_PG:   pg_reg    <= mul_q;
            MUL_PB:   pb_reg    <= mul_q;
            MUL_RED:  red_c_reg <= sat16;
            MUL_GRN:  grn_c_reg <= sat16;
            MUL_BLU:  blu_c_reg <= sat17;
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            iter_reg   <= ITER_W'(count_reg);
            in_set_reg <= status.at_limit;
            red_reg    <= status.at_limit ? '0 : red_c_reg;
            green_reg  <= status.at_limit ? '0 : grn_c_reg;
            blue_reg   <= status.at_limit ? '0 : blu_c_reg;
        end
    end

    assign iterations = iter_reg;
    assign in_set     = in_set_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;

endmodule

/* hw/rtl/met_controller.sv */
// ----------------------------------------------------------------------------
// met_controller: sequencer of the escape-time color block
// Steps one point through iteration, division and palette phases and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
module met_controller import met_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  met_status_t status,
    output met_cmd_t    cmd
);

    localparam int DCW = $clog2(T_FRAC);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ITER,
        S_DIV,
        S_MUL,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic [DCW-1:0] div_cnt_reg;
    met_mul_op_t op_reg;
    logic        out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.iter     = (state_reg == S_ITER) && !status.escape;
        cmd.div_init = (state_reg == S_ITER) && status.escape && !status.at_limit;
        cmd.div_step = (state_reg == S_DIV);
        cmd.mul_op   = (state_reg == S_MUL) ? op_reg : MUL_NONE;
        cmd.out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            op_reg        <= MUL_T2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (status.escape)
                    begin
                        div_cnt_reg <= '0;
                        state_reg   <= status.at_limit ? S_DONE : S_DIV;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                    if (div_cnt_reg == DCW'(T_FRAC - 1))
                    begin
                        op_reg    <= MUL_T2;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    op_reg <= met_next_op(op_reg);
                    if (op_reg == MUL_BLU)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/mandelbrot_escape_time_color.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_color: escape-time evaluator with color palette
// Takes a point c, iterates z = z*z + c and returns the count and a color.
// ----------------------------------------------------------------------------
// Usage:
//   point  : valid/ready sink, one word holds c_re and c_im (signed,
//            COORD_FRAC_BITS fraction bits).
//   result : valid/ready source, one word per point: iterations, in_set and
//            the red, green, blue palette channels (black inside the set).
//   cfg_we / cfg_wdata : write of the iteration limit, only while idle.
// Flow: a point is loaded, then taken through its complex iterations (one
//   iteration per cycle through the squaring multipliers). Points inside the
//   set then go to the output register; escaping points first pass through
//   the radix-2 divider for t and the shared palette multiplier. One point
//   is worked at a time; a new point is taken as soon as the previous result
//   sits in the output register.
// Reset: the iteration limit returns to 200, the sequencer idles, no result
//   is valid.
// Stall: a held result stays in the output register; a finished point waits
//   until that register is free, and no new point is taken meanwhile.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_color import met_pkg::*; #(
    parameter int COORD_FRAC_BITS = 27,
    parameter int ITER_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ITER_W-1:0] cfg_wdata,
    met_point_if.sink         point,
    met_result_if.source      result
);

    localparam int IW = (ITER_BITS < ITER_W) ? ITER_BITS : ITER_W;

    logic [IW-1:0] limit_reg;
    met_cmd_t      cmd;
    met_status_t   status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= IW'(LIMIT_RESET);
        else if (cfg_we)
            limit_reg <= cfg_wdata[IW-1:0];
    end

    met_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    met_datapath #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .ITER_BITS       (ITER_BITS)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .status     (status),
        .iter_limit (limit_reg),
        .c_re       (point.c_re),
        .c_im       (point.c_im),
        .iterations (result.iterations),
        .in_set     (result.in_set),
        .red        (result.red),
        .green      (result.green),
        .blue       (result.blue)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> !point.ready)
        else $error("point taken while a point is in progress");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result.valid || result.ready))
        else $error("result word overwritten before it was taken");

    a_in_set_black: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.in_set |->
            (result.red == '0) && (result.green == '0) && (result.blue == '0))
        else $error("point inside the set is not black");
`endif

endmodule

/* tb/sv/tb_mandelbrot_escape_time_color.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_color: regression for the escape-time color block
// Sends points over the point channel and checks each result word against a
// local escape-time and palette predictor. Covers edge coordinates, the
// iteration limit at 0, 1, 65535 and a sweep of mid values, under changing
// idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_color import met_pkg::*; ();

    localparam int FRAC_BITS = 27;
    localparam longint ESCAPE_MAG = 64'sd4 <<< FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;
    localparam int POINTS_PER_PHASE = 67;
    localparam int SWEEP_LIMITS [6] = '{200, 16, 1000, 3, 255, 64};

    typedef struct packed {
        logic [ITER_W-1:0]  iterations;
        logic               in_set;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [ITER_W-1:0] cfg_wdata;

    met_point_if  point_ch ();
    met_result_if result_ch ();

    mandelbrot_escape_time_color dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .point     (point_ch),
        .result    (result_ch)
    );

    pixel_t            pending_pixels [$];
    logic [ITER_W-1:0] iter_limit;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                mismatches = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [COORD_W-1:0] to_q27(input real v);
        return $rtoi(v * 134217728.0);
    endfunction

    function automatic longint unsigned q16_mul(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b) >> T_FRAC;
    endfunction

    function automatic logic [COLOR_W-1:0] clamp_color(input longint unsigned v);
        return (v > 255) ? COLOR_MAX : v[COLOR_W-1:0];
    endfunction

    function automatic pixel_t escape_pixel(input logic signed [COORD_W-1:0] re,
                                            input logic signed [COORD_W-1:0] im,
                                            input logic [ITER_W-1:0] limit);
        longint          x, y, xx, yy, nx, cr, ci;
        longint unsigned count, t, u, t2, t3, u2, u3;
        pixel_t          px;
        cr = re;
        ci = im;
        x = 0;
        y = 0;
        count = 0;
        while (1)
        begin
            xx = (x * x) >>> FRAC_BITS;
            yy = (y * y) >>> FRAC_BITS;
            if (xx + yy > ESCAPE_MAG || count >= limit)
                break;
            nx = xx - yy + cr;
            y = (((x * y) >>> FRAC_BITS) <<< 1) + ci;
            x = nx;
            count++;
        end
        px = '0;
        px.iterations = count[ITER_W-1:0];
        px.in_set = (count == limit);
        if (!px.in_set)
        begin
            t = (count << T_FRAC) / limit;
            u = 65536 - t;
            t2 = q16_mul(t, t);
            t3 = q16_mul(t2, t);
            u2 = q16_mul(u, u);
            u3 = q16_mul(u2, u);
            px.red = clamp_color((RED_K * q16_mul(u, t3)) >> 16);
            px.green = clamp_color((GRN_K * q16_mul(u2, t2)) >> 16);
            px.blue = clamp_color((BLU_K * q16_mul(u3, t)) >> 17);
        end
        return px;
    endfunction

    task automatic check_pixel();
        pixel_t got, want;
        got.iterations = result_ch.iterations;
        got.in_set = result_ch.in_set;
        got.red = result_ch.red;
        got.green = result_ch.green;
        got.blue = result_ch.blue;
        if (pending_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: result word with no point pending: iter=%0d in_set=%0b",
                         $time, got.iterations, got.in_set);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.iterations !== want.iterations || got.in_set !== want.in_set ||
            got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("%0t: mismatch exp iter=%0d in_set=%0b rgb=%0d/%0d/%0d",
                         $time, want.iterations, want.in_set, want.red, want.green,
                         want.blue);
                $display("    got iter=%0d in_set=%0b rgb=%0d/%0d/%0d",
                         got.iterations, got.in_set, got.red, got.green, got.blue);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
            check_pixel();
        if (point_ch.valid && point_ch.ready)
            pending_pixels.push_back(escape_pixel(point_ch.c_re, point_ch.c_im, iter_limit));
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_point(input logic signed [COORD_W-1:0] re,
                              input logic signed [COORD_W-1:0] im);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_ch.valid <= 1'b0;
            @(negedge clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.c_re <= re;
        point_ch.c_im <= im;
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_point();
        int re, im;
        if ($urandom_range(9) == 0)
            send_point($urandom, $urandom);
        else
        begin
            re = int'($urandom_range(469762048)) - 335544320;
            im = int'($urandom_range(402653184)) - 201326592;
            send_point(re, im);
        end
    endtask

    task automatic drain_results();
        point_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_iter_limit(input logic [ITER_W-1:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        iter_limit = value;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1: begin send_idle_pct = 57; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 57; end
            3: begin send_idle_pct = 7; recv_stall_pct = 7; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    task automatic test_directed();
        set_idling(0);
        send_point(0, 0);
        send_point(to_q27(-2.0), 0);
        send_point(to_q27(2.0), 0);
        send_point(to_q27(0.25), 0);
        send_point(to_q27(0.26), 0);
        send_point(to_q27(-1.0), 0);
        send_point(0, to_q27(1.0));
        send_point(to_q27(-0.75), to_q27(0.1));
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
        send_point(32'sh7fff_ffff, 32'sh8000_0000);
        send_point(32'shaaaa_aaaa, 32'sh5555_5555);
        send_point(32'sh0000_0001, 32'shffff_ffff);
    endtask

    task automatic test_limit_extremes();
        set_iter_limit(1);
        send_point(0, 0);
        send_point(32'sh5555_5555, 32'shaaaa_aaaa);
        send_random_point();
        // zero limit: every point is inside and black
        set_iter_limit(0);
        send_point(0, 0);
        send_point(32'sh8000_0000, 32'sh7fff_ffff);
        send_random_point();
        set_iter_limit(16'hffff);
        send_point(0, 0);
        send_point(to_q27(-1.0), 0);
        send_point(to_q27(2.0), 0);
        send_point($urandom, $urandom);
        send_point(to_q27(0.26), 0);
    endtask

    task automatic test_random_sweep();
        foreach (SWEEP_LIMITS[li])
        begin
            set_iter_limit(ITER_W'(SWEEP_LIMITS[li]));
            for (int mode = 0; mode < 4; mode++)
            begin
                set_idling(mode);
                repeat (POINTS_PER_PHASE)
                    send_random_point();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        point_ch.valid = 1'b0;
        point_ch.c_re = '0;
        point_ch.c_im = '0;
        iter_limit = ITER_W'(LIMIT_RESET);
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_limit_extremes();
        test_random_sweep();
        drain_results();
        set_idling(0);
        repeat (40) @(posedge clk);
        mismatches += pending_pixels.size();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/met_pkg.sv
hw/rtl/met_if.sv
hw/rtl/met_datapath.sv
hw/rtl/met_controller.sv
hw/rtl/mandelbrot_escape_time_color.sv
tb/sv/tb_mandelbrot_escape_time_color.sv
